/* hw/rtl/cra_pkg.sv */
package cra_pkg;

  localparam int TAG_W  = 32;
  localparam int SIZE_W = 21;
  localparam int ACT_W  = 2;
  localparam int FIT_W  = 2;
  localparam int STAT_W = 2;

  localparam logic [SIZE_W-1:0] MSIZE_RESET = 21'd1048576;

  localparam logic [ACT_W-1:0] ACT_REQUEST = 2'd0;
  localparam logic [ACT_W-1:0] ACT_RELEASE = 2'd1;
  localparam logic [ACT_W-1:0] ACT_COMPACT = 2'd2;
  localparam logic [ACT_W-1:0] ACT_REPORT  = 2'd3;

  localparam logic [FIT_W-1:0] FIT_BEST  = 2'd1;
  localparam logic [FIT_W-1:0] FIT_WORST = 2'd2;

  localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
  localparam logic [STAT_W-1:0] ST_NO_FIT    = 2'd1;
  localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [STAT_W-1:0] ST_FULL      = 2'd3;

  typedef enum logic [2:0] {
    OP_HOLD,
    OP_ROTATE,
    OP_INIT,
    OP_WRITE,
    OP_SQ_EVEN,
    OP_SQ_ODD
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    logic     b_en;
    logic     kill2;
    logic     shift;
  } cell_cmd_t;

endpackage

/* hw/rtl/cra_if.sv */
interface cra_in_if;
  logic                        valid;
  logic                        ready;
  logic [cra_pkg::ACT_W-1:0]   action;
  logic [cra_pkg::TAG_W-1:0]   owner;
  logic [cra_pkg::SIZE_W-1:0]  request_size;
  logic [cra_pkg::FIT_W-1:0]   fit_method;
  modport source (output valid, action, owner, request_size, fit_method, input ready);
  modport sink (input valid, action, owner, request_size, fit_method, output ready);
endinterface

interface cra_out_if #(parameter int ADDRESS_BITS = 20);
  logic                        valid;
  logic                        ready;
  logic [cra_pkg::STAT_W-1:0]  status;
  logic [ADDRESS_BITS-1:0]     region_start;
  logic [ADDRESS_BITS-1:0]     region_end;
  logic                        region_used;
  logic [cra_pkg::TAG_W-1:0]   region_owner;
  logic                        last;
  modport source (output valid, status, region_start, region_end, region_used,
                  region_owner, last, input ready);
  modport sink (input valid, status, region_start, region_end, region_used,
                region_owner, last, output ready);
endinterface

interface cra_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [cra_pkg::SIZE_W-1:0]  memory_size;
  modport source (output valid, memory_size, input ready);
  modport sink (input valid, memory_size, output ready);
endinterface

/* hw/rtl/contiguous_region_allocator.sv */
// Contiguous region allocator. The segment table lives in a ring of
// MAX_SEGMENTS cells; one pass rotates the whole ring once, and the
// controller looks only at the head cell. Every word takes one pass. A
// request that is granted adds an edit write; a found release adds an edit
// write and an odd/even squeeze that closes the gaps; a compact adds the
// squeeze and a write of one merged free hole. A report emits one word per
// segment, stalling the ring while the output word is not taken. The block
// takes one word at a time. A memory_size write reloads the table with one
// free hole once the block is idle; no word is taken until the reload is done.
module contiguous_region_allocator #(
  parameter int MAX_SEGMENTS = 32,
  parameter int ADDRESS_BITS = 20
) (
  input logic            clk,
  input logic            rst_n,
  cra_in_if.sink         in_ch,
  cra_out_if.source      out_ch,
  cra_cfg_if.sink        cfg_ch
);

  localparam int N  = MAX_SEGMENTS;
  localparam int AB = ADDRESS_BITS;
  localparam int IW = $clog2(N);
  localparam int CW = $clog2(N+1);
  localparam int LW = AB + 1;
  localparam int SW = cra_pkg::SIZE_W;
  localparam int MW = (SW > LW) ? SW : LW;
  localparam int TW = cra_pkg::TAG_W;
  localparam int EW = 2 + TW + 2*AB;
  localparam logic [MW-1:0] LIMIT  = MW'(1) << AB;
  localparam logic [IW-1:0] LAST_I = IW'(N-1);
  localparam logic [CW-1:0] FULL_C = CW'(N);

  typedef struct packed {
    logic          v;
    logic          owned;
    logic [TW-1:0] tag;
    logic [AB-1:0] s;
    logic [AB-1:0] e;
  } ent_t;

  typedef enum logic [2:0] {
    S_IDLE, S_PASS, S_DEC, S_EDIT, S_SQ, S_HOLE, S_RESP
  } state_t;

  function automatic logic [AB-1:0] size_to_end(input logic [SW-1:0] v);
    logic [MW-1:0] x;
    x = MW'(v);
    if (x == '0) x = MW'(1);
    if (x > LIMIT) x = LIMIT;
    return AB'(x - MW'(1));
  endfunction

  state_t                     state_r;
  logic [IW-1:0]              cnt_r;
  logic [CW-1:0]              count_r;
  logic                       init_pend_r;
  logic [AB-1:0]              init_end_r;
  logic [cra_pkg::ACT_W-1:0]  act_r;
  logic [TW-1:0]              own_r;
  logic [SW-1:0]              size_r;
  logic [cra_pkg::FIT_W-1:0]  meth_r;

  logic                       pick_v_r;
  logic [IW-1:0]              pick_idx_r;
  logic [AB-1:0]              pick_s_r;
  logic [AB-1:0]              pick_e_r;
  logic [LW-1:0]              pick_len_r;

  logic                       found_r;
  logic                       look_r;
  logic [IW-1:0]              f_idx_r;
  logic [AB-1:0]              fs_r;
  logic [AB-1:0]              fe_r;
  logic                       prevf_r;
  logic [AB-1:0]              pstart_r;
  logic                       nextf_r;
  logic [AB-1:0]              nend_r;
  logic                       prev_v_r;
  logic                       prev_own_r;
  logic [AB-1:0]              prev_s_r;

  logic [LW-1:0]              pos_r;
  logic [LW-1:0]              free_r;
  logic [CW-1:0]              w_r;

  logic [cra_pkg::STAT_W-1:0] res_status_r;
  logic [AB-1:0]              res_s_r;
  logic [AB-1:0]              res_e_r;
  logic                       res_used_r;

  logic                       out_v_r;
  logic [cra_pkg::STAT_W-1:0] o_status_r;
  logic [AB-1:0]              o_s_r;
  logic [AB-1:0]              o_e_r;
  logic                       o_used_r;
  logic [TW-1:0]              o_owner_r;
  logic                       o_last_r;

  ent_t                       cq [N];
  ent_t                       hd;
  ent_t                       tail;
  ent_t                       ea;
  ent_t                       eb;
  cra_pkg::cell_cmd_t         cmd;
  logic [IW-1:0]              k;

  logic [LW-1:0]              hlen;
  logic                       cand;
  logic                       take;
  logic                       exact;
  logic [AB-1:0]              end_new;
  logic [AB-1:0]              merged_end;
  logic                       step;
  logic                       slot_free;
  logic                       hole_en;

  assign hd        = cq[0];
  assign hlen      = LW'(hd.e) - LW'(hd.s) + LW'(1);
  assign slot_free = !out_v_r || out_ch.ready;
  assign step      = !(act_r == cra_pkg::ACT_REPORT && hd.v && !slot_free);
  assign cand      = hd.v && !hd.owned && size_r != '0 && MW'(hlen) >= MW'(size_r);
  assign take      = cand && (!pick_v_r ||
                     (meth_r == cra_pkg::FIT_BEST && hlen < pick_len_r) ||
                     (meth_r == cra_pkg::FIT_WORST && hlen > pick_len_r));
  assign exact      = MW'(pick_len_r) == MW'(size_r);
  assign end_new    = AB'(MW'(pick_s_r) + MW'(size_r) - MW'(1));
  assign merged_end = nextf_r ? nend_r : fe_r;
  assign hole_en    = free_r != '0 && w_r < FULL_C;

  assign in_ch.ready         = (state_r == S_IDLE) && !init_pend_r;
  assign cfg_ch.ready        = 1'b1;
  assign out_ch.valid        = out_v_r;
  assign out_ch.status       = o_status_r;
  assign out_ch.region_start = o_s_r;
  assign out_ch.region_end   = o_e_r;
  assign out_ch.region_used  = o_used_r;
  assign out_ch.region_owner = o_owner_r;
  assign out_ch.last         = o_last_r;

  always_comb begin
    cmd   = '{op: cra_pkg::OP_HOLD, b_en: 1'b0, kill2: 1'b0, shift: 1'b0};
    k     = '0;
    ea    = '0;
    eb    = '0;
    tail  = hd;
    case (state_r)
      S_IDLE: begin
        if (init_pend_r) begin
          cmd.op = cra_pkg::OP_INIT;
          ea     = '{v: 1'b1, owned: 1'b0, tag: '0, s: '0, e: init_end_r};
        end
      end
      S_PASS: begin
        if (step) cmd.op = cra_pkg::OP_ROTATE;
        if (act_r == cra_pkg::ACT_COMPACT && hd.v) begin
          if (hd.owned) begin
            tail = '{v: 1'b1, owned: 1'b1, tag: hd.tag, s: AB'(pos_r),
                     e: AB'(pos_r + hlen - LW'(1))};
          end else begin
            tail = '0;
          end
        end
      end
      S_EDIT: begin
        cmd.op = cra_pkg::OP_WRITE;
        if (act_r == cra_pkg::ACT_REQUEST) begin
          k          = pick_idx_r;
          ea         = '{v: 1'b1, owned: 1'b1, tag: own_r, s: pick_s_r, e: end_new};
          eb         = '{v: 1'b1, owned: 1'b0, tag: '0, s: end_new + AB'(1), e: pick_e_r};
          cmd.b_en   = !exact;
          cmd.shift  = !exact;
        end else if (prevf_r) begin
          k          = f_idx_r - IW'(1);
          ea         = '{v: 1'b1, owned: 1'b0, tag: '0, s: pstart_r, e: merged_end};
          cmd.b_en   = 1'b1;
          cmd.kill2  = nextf_r;
        end else begin
          k          = f_idx_r;
          ea         = '{v: 1'b1, owned: 1'b0, tag: '0, s: fs_r, e: merged_end};
          cmd.b_en   = nextf_r;
        end
      end
      S_SQ: begin
        cmd.op = cnt_r[0] ? cra_pkg::OP_SQ_ODD : cra_pkg::OP_SQ_EVEN;
        tail   = '0;
      end
      S_HOLE: begin
        if (hole_en) begin
          cmd.op = cra_pkg::OP_WRITE;
          k      = w_r[IW-1:0];
          ea     = '{v: 1'b1, owned: 1'b0, tag: '0, s: AB'(pos_r),
                     e: AB'(pos_r + free_r - LW'(1))};
        end
      end
      default: ;
    endcase
  end

  for (genvar gi = 0; gi < N; gi++) begin : g_cell
    cra_cell #(.N(N), .EW(EW), .IDX(gi)) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .cmd   (cmd),
      .k     (k),
      .a     (ea),
      .b     (eb),
      .left  ((gi > 0) ? cq[(gi > 0) ? gi-1 : 0] : ent_t'('0)),
      .right ((gi < N-1) ? cq[(gi < N-1) ? gi+1 : 0] : tail),
      .q     (cq[gi])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      count_r     <= CW'(1);
      init_pend_r <= 1'b1;
      init_end_r  <= size_to_end(cra_pkg::MSIZE_RESET);
      out_v_r     <= 1'b0;
    end else begin
      if (out_ch.ready) out_v_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (init_pend_r) begin
            init_pend_r <= 1'b0;
            count_r     <= CW'(1);
          end else if (in_ch.valid) begin
            act_r    <= in_ch.action;
            own_r    <= in_ch.owner;
            size_r   <= in_ch.request_size;
            meth_r   <= in_ch.fit_method;
            cnt_r    <= '0;
            pick_v_r <= 1'b0;
            found_r  <= 1'b0;
            look_r   <= 1'b0;
            prevf_r  <= 1'b0;
            nextf_r  <= 1'b0;
            prev_v_r <= 1'b0;
            pos_r    <= '0;
            free_r   <= '0;
            w_r      <= '0;
            state_r  <= S_PASS;
          end
        end
        S_PASS: begin
          if (step) begin
            cnt_r      <= cnt_r + IW'(1);
            prev_v_r   <= hd.v;
            prev_own_r <= hd.owned;
            prev_s_r   <= hd.s;
            case (act_r)
              cra_pkg::ACT_REQUEST: begin
                if (take) begin
                  pick_v_r   <= 1'b1;
                  pick_idx_r <= cnt_r;
                  pick_s_r   <= hd.s;
                  pick_e_r   <= hd.e;
                  pick_len_r <= hlen;
                end
              end
              cra_pkg::ACT_RELEASE: begin
                if (look_r) begin
                  look_r <= 1'b0;
                  if (hd.v && !hd.owned) begin
                    nextf_r <= 1'b1;
                    nend_r  <= hd.e;
                  end
                end
                if (!found_r && hd.v && hd.owned && hd.tag == own_r) begin
                  found_r  <= 1'b1;
                  look_r   <= 1'b1;
                  f_idx_r  <= cnt_r;
                  fs_r     <= hd.s;
                  fe_r     <= hd.e;
                  prevf_r  <= prev_v_r && !prev_own_r;
                  pstart_r <= prev_s_r;
                end
              end
              cra_pkg::ACT_COMPACT: begin
                if (hd.v) begin
                  if (hd.owned) begin
                    pos_r <= pos_r + hlen;
                    w_r   <= w_r + CW'(1);
                  end else begin
                    free_r <= free_r + hlen;
                  end
                end
              end
              default: begin
                if (hd.v) begin
                  out_v_r    <= 1'b1;
                  o_status_r <= cra_pkg::ST_OK;
                  o_s_r      <= hd.s;
                  o_e_r      <= hd.e;
                  o_used_r   <= hd.owned;
                  o_owner_r  <= hd.owned ? hd.tag : '0;
                  o_last_r   <= (CW'(cnt_r) + CW'(1)) == count_r;
                end
              end
            endcase
            if (cnt_r == LAST_I) state_r <= S_DEC;
          end
        end
        S_DEC: begin
          cnt_r        <= '0;
          res_status_r <= cra_pkg::ST_OK;
          res_s_r      <= '0;
          res_e_r      <= '0;
          res_used_r   <= 1'b0;
          case (act_r)
            cra_pkg::ACT_REQUEST: begin
              if (!pick_v_r) begin
                res_status_r <= cra_pkg::ST_NO_FIT;
                state_r      <= S_RESP;
              end else if (!exact && count_r == FULL_C) begin
                res_status_r <= cra_pkg::ST_FULL;
                state_r      <= S_RESP;
              end else begin
                res_s_r    <= pick_s_r;
                res_e_r    <= end_new;
                res_used_r <= 1'b1;
                state_r    <= S_EDIT;
              end
            end
            cra_pkg::ACT_RELEASE: begin
              if (!found_r) begin
                res_status_r <= cra_pkg::ST_NOT_FOUND;
                state_r      <= S_RESP;
              end else begin
                res_s_r <= fs_r;
                res_e_r <= fe_r;
                state_r <= S_EDIT;
              end
            end
            cra_pkg::ACT_COMPACT: state_r <= S_SQ;
            default: state_r <= S_IDLE;
          endcase
        end
        S_EDIT: begin
          if (act_r == cra_pkg::ACT_REQUEST) begin
            if (!exact) count_r <= count_r + CW'(1);
            state_r <= S_RESP;
          end else begin
            count_r <= count_r - CW'(prevf_r) - CW'(nextf_r);
            state_r <= S_SQ;
          end
        end
        S_SQ: begin
          cnt_r <= cnt_r + IW'(1);
          if (cnt_r == LAST_I) begin
            state_r <= (act_r == cra_pkg::ACT_COMPACT) ? S_HOLE : S_RESP;
          end
        end
        S_HOLE: begin
          count_r <= w_r + CW'(hole_en);
          state_r <= S_RESP;
        end
        S_RESP: begin
          if (slot_free) begin
            out_v_r    <= 1'b1;
            o_status_r <= res_status_r;
            o_s_r      <= res_s_r;
            o_e_r      <= res_e_r;
            o_used_r   <= res_used_r;
            o_owner_r  <= (act_r == cra_pkg::ACT_COMPACT ||
                           res_status_r != cra_pkg::ST_OK) ? '0 : own_r;
            o_last_r   <= 1'b1;
            state_r    <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
      if (cfg_ch.valid) begin
        init_pend_r <= 1'b1;
        init_end_r  <= size_to_end(cfg_ch.memory_size);
      end
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r != '0 && count_r <= FULL_C)
    else $error("segment count out of range");

  a_head_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && !init_pend_r) |-> cq[0].v)
    else $error("head cell empty while idle");

  a_full_ring: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && !init_pend_r && cq[N-1].v) |-> count_r == FULL_C)
    else $error("last cell holds a segment but table is not full");

  a_req_grow: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EDIT && act_r == cra_pkg::ACT_REQUEST) |=>
      (count_r == $past(count_r) || count_r == $past(count_r) + CW'(1)))
    else $error("request changed segment count by more than one");

endmodule

/* hw/rtl/cra_cell.sv */
module cra_cell #(
  parameter int N   = 2,
  parameter int EW  = 8,
  parameter int IDX = 0
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  cra_pkg::cell_cmd_t   cmd,
  input  logic [$clog2(N)-1:0] k,
  input  logic [EW-1:0]        a,
  input  logic [EW-1:0]        b,
  input  logic [EW-1:0]        left,
  input  logic [EW-1:0]        right,
  output logic [EW-1:0]        q
);

  localparam int KW = $clog2(N);
  localparam logic [KW:0] ME    = (KW+1)'(IDX);
  localparam logic [KW:0] ONE   = (KW+1)'(1);
  localparam logic [KW:0] TWO   = (KW+1)'(2);
  localparam bit          HAS_L = (IDX > 0);
  localparam bit          HAS_R = (IDX < N-1);
  localparam bit          PAR   = (IDX % 2) == 1;

  logic          v_r;
  logic [EW-2:0] pay_r;
  logic [EW-1:0] cur;
  logic [EW-1:0] q_nxt;
  logic [KW:0]   kx;
  logic          phase;

  assign cur   = {v_r, pay_r};
  assign q     = cur;
  assign kx    = {1'b0, k};
  assign phase = (cmd.op == cra_pkg::OP_SQ_ODD);

  always_comb begin
    q_nxt = cur;
    case (cmd.op)
      cra_pkg::OP_ROTATE: q_nxt = right;
      cra_pkg::OP_INIT: begin
        q_nxt = (IDX == 0) ? a : '0;
      end
      cra_pkg::OP_WRITE: begin
        if (ME == kx) begin
          q_nxt = a;
        end else if (ME == kx + ONE && cmd.b_en) begin
          q_nxt = b;
        end else if (ME == kx + TWO && cmd.kill2) begin
          q_nxt = '0;
        end else if (ME > kx + ONE && cmd.shift) begin
          q_nxt = left;
        end
      end
      cra_pkg::OP_SQ_EVEN, cra_pkg::OP_SQ_ODD: begin
        if (PAR == phase) begin
          if (HAS_R && !v_r && right[EW-1]) q_nxt = right;
        end else begin
          if (HAS_L && !left[EW-1] && v_r) q_nxt = left;
        end
      end
      default: q_nxt = cur;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else begin
      v_r <= q_nxt[EW-1];
    end
  end

  always_ff @(posedge clk) begin
    pay_r <= q_nxt[EW-2:0];
  end

endmodule

/* test/tb_contiguous_region_allocator.sv */
module tb_contiguous_region_allocator;

  localparam int NSEG = 32;
  localparam int AW   = 20;
  localparam int SW   = cra_pkg::SIZE_W;
  localparam int TW   = cra_pkg::TAG_W;
  localparam int ACW  = cra_pkg::ACT_W;
  localparam int FW   = cra_pkg::FIT_W;
  localparam int STW  = cra_pkg::STAT_W;
  localparam logic [SW-1:0] MEM_MAX = 21'd1048576;

  typedef struct packed {
    logic [STW-1:0] status;
    logic [AW-1:0]  rstart;
    logic [AW-1:0]  rend;
    logic           used;
    logic [TW-1:0]  owner;
    logic           last;
  } region_word_t;

  typedef struct packed {
    logic [ACW-1:0] action;
    logic [TW-1:0]  owner;
    logic [SW-1:0]  req_size;
    logic [FW-1:0]  fit;
    logic           has_exp;
    region_word_t   exp_word;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  always #4 clk = ~clk;

  cra_in_if in_ch();
  cra_out_if #(.ADDRESS_BITS(AW)) out_ch();
  cra_cfg_if cfg_ch();

  contiguous_region_allocator #(.MAX_SEGMENTS(NSEG), .ADDRESS_BITS(AW)) uut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_ch(cfg_ch.sink)
  );

  // allocator shadow
  logic [SW-1:0]    mem_units;
  logic [AW:0]      seg_lo [NSEG];
  logic [AW:0]      seg_hi [NSEG];
  logic             seg_own [NSEG];
  logic [TW-1:0]    seg_tag [NSEG];
  int               seg_n;

  region_word_t pending_words[$];
  region_word_t typed_words[$];
  logic         typed_valid[$];
  int errors = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  logic hold_go = 1'b0;
  int hold_cnt = 0;

  function automatic region_word_t mk(logic [STW-1:0] st, logic [AW:0] a, logic [AW:0] b,
                                      logic u, logic [TW-1:0] t, logic l);
    region_word_t w;
    w.status = st; w.rstart = a[AW-1:0]; w.rend = b[AW-1:0];
    w.used = u; w.owner = t; w.last = l;
    return w;
  endfunction

  task automatic table_reload(input logic [SW-1:0] v);
    if (v < 21'd1) v = 21'd1;
    if (v > MEM_MAX) v = MEM_MAX;
    mem_units = v;
    for (int i = 0; i < NSEG; i++) begin
      seg_lo[i] = '0; seg_hi[i] = '0; seg_own[i] = 1'b0; seg_tag[i] = '0;
    end
    seg_hi[0] = mem_units - 21'd1;
    seg_n = 1;
  endtask

  task automatic drop_seg(input int j);
    for (int i = j; i + 1 < seg_n; i++) begin
      seg_lo[i] = seg_lo[i+1]; seg_hi[i] = seg_hi[i+1];
      seg_own[i] = seg_own[i+1]; seg_tag[i] = seg_tag[i+1];
    end
    seg_n--;
  endtask

  task automatic predict_allocator(input logic [ACW-1:0] act, input logic [TW-1:0] tag,
                                   input logic [SW-1:0] sz, input logic [FW-1:0] fit);
    int pick;
    logic [AW:0] plen, len, old_hi, pos, freeu, s, e;
    int i, w;
    pick = -1; plen = '0;
    case (act)
      cra_pkg::ACT_REQUEST: begin
        if (sz >= 21'd1) begin
          for (i = 0; i < seg_n; i++) begin
            if (seg_own[i]) continue;
            len = seg_hi[i] - seg_lo[i] + 1'b1;
            if (len < sz) continue;
            if (pick < 0 || (fit == cra_pkg::FIT_BEST && len < plen) ||
                (fit == cra_pkg::FIT_WORST && len > plen)) begin
              pick = i; plen = len;
            end
            if (fit != cra_pkg::FIT_BEST && fit != cra_pkg::FIT_WORST) break;
          end
        end
        if (pick < 0) begin
          pending_words.push_back(mk(cra_pkg::ST_NO_FIT, 0, 0, 0, 0, 1));
        end else if (plen != sz && seg_n >= NSEG) begin
          pending_words.push_back(mk(cra_pkg::ST_FULL, 0, 0, 0, 0, 1));
        end else begin
          if (plen != sz) begin
            old_hi = seg_hi[pick];
            for (i = seg_n; i > pick + 1; i--) begin
              seg_lo[i] = seg_lo[i-1]; seg_hi[i] = seg_hi[i-1];
              seg_own[i] = seg_own[i-1]; seg_tag[i] = seg_tag[i-1];
            end
            seg_hi[pick] = seg_lo[pick] + sz - 1'b1;
            seg_lo[pick+1] = seg_hi[pick] + 1'b1;
            seg_hi[pick+1] = old_hi;
            seg_own[pick+1] = 1'b0; seg_tag[pick+1] = '0;
            seg_n++;
          end
          seg_own[pick] = 1'b1; seg_tag[pick] = tag;
          pending_words.push_back(mk(cra_pkg::ST_OK, seg_lo[pick], seg_hi[pick], 1, tag, 1));
        end
      end
      cra_pkg::ACT_RELEASE: begin
        for (i = 0; i < seg_n; i++) if (seg_own[i] && seg_tag[i] == tag) break;
        if (i >= seg_n) begin
          pending_words.push_back(mk(cra_pkg::ST_NOT_FOUND, 0, 0, 0, 0, 1));
        end else begin
          s = seg_lo[i]; e = seg_hi[i];
          seg_own[i] = 1'b0; seg_tag[i] = '0;
          if (i + 1 < seg_n && !seg_own[i+1]) begin
            seg_hi[i] = seg_hi[i+1]; drop_seg(i + 1);
          end
          if (i > 0 && !seg_own[i-1]) begin
            seg_hi[i-1] = seg_hi[i]; drop_seg(i);
          end
          pending_words.push_back(mk(cra_pkg::ST_OK, s, e, 0, tag, 1));
        end
      end
      cra_pkg::ACT_COMPACT: begin
        w = 0; pos = '0; freeu = '0;
        for (i = 0; i < seg_n; i++) begin
          len = seg_hi[i] - seg_lo[i] + 1'b1;
          if (seg_own[i]) begin
            seg_lo[w] = pos; seg_hi[w] = pos + len - 1'b1; seg_tag[w] = seg_tag[i];
            seg_own[w] = 1'b1; pos = pos + len; w++;
          end else begin
            freeu = freeu + len;
          end
        end
        if (freeu != '0 && w < NSEG) begin
          seg_lo[w] = pos; seg_hi[w] = pos + freeu - 1'b1; seg_own[w] = 1'b0; seg_tag[w] = '0;
          w++;
        end
        seg_n = w;
        pending_words.push_back(mk(cra_pkg::ST_OK, 0, 0, 0, 0, 1));
      end
      default: begin
        for (i = 0; i < seg_n; i++)
          pending_words.push_back(mk(cra_pkg::ST_OK, seg_lo[i], seg_hi[i], seg_own[i],
                                     seg_own[i] ? seg_tag[i] : '0, i + 1 == seg_n));
      end
    endcase
  endtask

  task automatic send_word(input logic [ACW-1:0] act, input logic [TW-1:0] tag,
                           input logic [SW-1:0] sz, input logic [FW-1:0] fit);
    if ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.action <= act; in_ch.owner <= tag; in_ch.request_size <= sz; in_ch.fit_method <= fit;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predict_allocator(act, tag, sz, fit);
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic write_size(input logic [SW-1:0] v);
    cfg_ch.valid <= 1'b1;
    cfg_ch.memory_size <= v;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    table_reload(v);
    @(posedge clk);
  endtask

  function automatic logic [TW-1:0] pick_tag();
    if ($urandom_range(3) == 0) return $urandom();
    return {8'h41, 8'h42, 8'h43, 8'h30 + 8'($urandom_range(7))};
  endfunction

  task automatic random_words(input int n, input int span);
    int r;
    logic [SW-1:0] sz;
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(99);
      if ($urandom_range(9) == 0) sz = SW'($urandom());
      else sz = SW'($urandom_range(span));
      if (r < 50) send_word(cra_pkg::ACT_REQUEST, pick_tag(), sz, FW'($urandom_range(3)));
      else if (r < 82) send_word(cra_pkg::ACT_RELEASE, pick_tag(), sz, FW'($urandom_range(3)));
      else if (r < 90) send_word(cra_pkg::ACT_COMPACT, $urandom(), SW'($urandom()),
                                 FW'($urandom_range(3)));
      else send_word(cra_pkg::ACT_REPORT, $urandom(), SW'($urandom()),
                     FW'($urandom_range(3)));
    end
  endtask

  // receive side
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (hold_go && hold_cnt < 600) begin
      out_ch.ready <= 1'b0;
      hold_cnt <= hold_cnt + 1;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    region_word_t got, want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = mk(out_ch.status, {1'b0, out_ch.region_start}, {1'b0, out_ch.region_end},
               out_ch.region_used, out_ch.region_owner, out_ch.last);
      if (pending_words.size() == 0) begin
        $display("%0t: unexpected word %h", $time, got);
        errors++;
      end else begin
        want = pending_words.pop_front();
        if (typed_valid.size() != 0) begin
          if (typed_valid.pop_front() && typed_words[0] != want) begin
            $display("%0t: table row mismatch: expected %h, actual %h",
                     $time, typed_words[0], want);
            errors++;
          end
          typed_words.pop_front();
        end
        if (got.status != want.status || got.rstart != want.rstart ||
            got.rend != want.rend || got.used != want.used ||
            got.owner != want.owner || got.last != want.last) begin
          $display("%0t: mismatch: expected %h, actual %h", $time, want, got);
          errors++;
        end
      end
    end
  end

  stim_row_t dir_rows[$];

  function automatic stim_row_t row(logic [ACW-1:0] a, logic [TW-1:0] t,
                                    logic [SW-1:0] s, logic [FW-1:0] f,
                                    logic h, region_word_t w);
    stim_row_t r;
    r.action = a; r.owner = t; r.req_size = s; r.fit = f; r.has_exp = h; r.exp_word = w;
    return r;
  endfunction

  initial begin
    int n0;
    in_ch.valid = 1'b0; in_ch.action = cra_pkg::ACT_REQUEST; in_ch.owner = '0;
    in_ch.request_size = '0; in_ch.fit_method = '0;
    cfg_ch.valid = 1'b0; cfg_ch.memory_size = '0;
    table_reload(cra_pkg::MSIZE_RESET);
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    dir_rows.push_back(row(cra_pkg::ACT_REPORT, 0, 0, 0, 1,
                           mk(cra_pkg::ST_OK, 0, MEM_MAX - 21'd1, 0, 0, 1)));
    dir_rows.push_back(row(cra_pkg::ACT_REQUEST, 32'hFFFF_FFFF, 0, 0, 1,
                           mk(cra_pkg::ST_NO_FIT, 0, 0, 0, 0, 1)));
    dir_rows.push_back(row(cra_pkg::ACT_REQUEST, 1, 21'h1F_FFFF, 0, 1,
                           mk(cra_pkg::ST_NO_FIT, 0, 0, 0, 0, 1)));
    dir_rows.push_back(row(cra_pkg::ACT_RELEASE, 7, 0, 0, 1,
                           mk(cra_pkg::ST_NOT_FOUND, 0, 0, 0, 0, 1)));
    dir_rows.push_back(row(cra_pkg::ACT_REQUEST, 32'hFFFF_FFFF, 1, 0, 1,
                           mk(cra_pkg::ST_OK, 0, 0, 1, 32'hFFFF_FFFF, 1)));
    dir_rows.push_back(row(cra_pkg::ACT_REQUEST, 2, 100, cra_pkg::FIT_BEST, 0, '0));
    dir_rows.push_back(row(cra_pkg::ACT_REQUEST, 3, 10, cra_pkg::FIT_WORST, 0, '0));
    dir_rows.push_back(row(cra_pkg::ACT_REQUEST, 4, 5, 2'd3, 0, '0));
    dir_rows.push_back(row(cra_pkg::ACT_RELEASE, 2, 0, 0, 0, '0));
    dir_rows.push_back(row(cra_pkg::ACT_REQUEST, 5, 50, cra_pkg::FIT_BEST, 0, '0));
    dir_rows.push_back(row(cra_pkg::ACT_REQUEST, 6, 50, 0, 0, '0));
    dir_rows.push_back(row(cra_pkg::ACT_RELEASE, 32'hFFFF_FFFF, 0, 0, 0, '0));
    dir_rows.push_back(row(cra_pkg::ACT_REPORT, 0, 0, 0, 0, '0));
    dir_rows.push_back(row(cra_pkg::ACT_COMPACT, 0, 0, 0, 1,
                           mk(cra_pkg::ST_OK, 0, 0, 0, 0, 1)));
    dir_rows.push_back(row(cra_pkg::ACT_REPORT, 0, 0, 0, 0, '0));
    dir_rows.push_back(row(cra_pkg::ACT_RELEASE, 3, 0, 0, 0, '0));
    dir_rows.push_back(row(cra_pkg::ACT_RELEASE, 4, 0, 0, 0, '0));
    dir_rows.push_back(row(cra_pkg::ACT_RELEASE, 5, 0, 0, 0, '0));
    dir_rows.push_back(row(cra_pkg::ACT_RELEASE, 6, 0, 0, 0, '0));
    dir_rows.push_back(row(cra_pkg::ACT_COMPACT, 0, 0, 0, 1,
                           mk(cra_pkg::ST_OK, 0, 0, 0, 0, 1)));
    dir_rows.push_back(row(cra_pkg::ACT_REQUEST, 9, MEM_MAX, cra_pkg::FIT_WORST, 1,
                           mk(cra_pkg::ST_OK, 0, MEM_MAX - 21'd1, 1, 9, 1)));
    dir_rows.push_back(row(cra_pkg::ACT_COMPACT, 0, 0, 0, 1,
                           mk(cra_pkg::ST_OK, 0, 0, 0, 0, 1)));
    dir_rows.push_back(row(cra_pkg::ACT_REPORT, 0, 0, 0, 1,
                           mk(cra_pkg::ST_OK, 0, MEM_MAX - 21'd1, 1, 9, 1)));
    foreach (dir_rows[k]) begin
      n0 = pending_words.size();
      send_word(dir_rows[k].action, dir_rows[k].owner, dir_rows[k].req_size, dir_rows[k].fit);
      for (int j = n0; j < pending_words.size(); j++) begin
        typed_words.push_back(dir_rows[k].exp_word);
        typed_valid.push_back(dir_rows[k].has_exp && j == n0);
      end
      wait_drained();
      typed_words.delete(); typed_valid.delete();
    end

    // table full: 1-unit carves
    write_size(21'd40);
    for (int k = 0; k < 34; k++) send_word(cra_pkg::ACT_REQUEST, k, 1, 0);
    send_word(cra_pkg::ACT_REPORT, 0, 0, 0);
    wait_drained();
    write_size(21'd1);
    send_word(cra_pkg::ACT_REQUEST, 1, 1, cra_pkg::FIT_BEST);
    send_word(cra_pkg::ACT_COMPACT, 0, 0, 0);
    send_word(cra_pkg::ACT_REPORT, 0, 0, 0);
    wait_drained();

    write_size(21'd0);
    random_words(20, 3);
    wait_drained();
    write_size(21'h1F_FFFF);
    random_words(50, 100000);
    wait_drained();

    write_size(21'd200);
    send_idle_pct = 73;
    random_words(50, 40);
    wait_drained();
    write_size(21'd1000);
    send_idle_pct = 0; recv_stall_pct = 73;
    random_words(50, 120);
    wait_drained();
    write_size(21'd64);
    send_idle_pct = 25; recv_stall_pct = 25;
    random_words(50, 12);
    wait_drained();
    send_idle_pct = 0; recv_stall_pct = 0;
    hold_go <= 1'b1;
    random_words(50, 30);
    wait_drained();

    if (errors == 0) begin
      $display("** contiguous_region_allocator: PASSED **");
    end else begin
      $display("** contiguous_region_allocator: FAILED **");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("** contiguous_region_allocator: FAILED **");
    $finish;
  end

endmodule
